// File: sv/elst_pkg.sv
// shared types and constants for the event latency statistics table
// no dependencies
package elst_pkg;

  localparam int unsigned SLOTS_DEF = 512;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // word kinds
  localparam logic [KIND_W-1:0] KIND_RECORD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREEZE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FROZEN = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEADY_MODE   = 1'd1;

  // one table row
  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] total;
    logic [DATA_W-1:0] max;
  } entry_t;

  // running totals kept outside the table
  typedef struct packed {
    logic [DATA_W-1:0] grand_count;
    logic [DATA_W-1:0] grand_time;
    logic [DATA_W-1:0] first_start;
  } totals_t;

endpackage

// File: sv/elst_mem.sv
// statistics row memory: one write port, one read port, registered read data
// depends on elst_pkg
module elst_mem import elst_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(SLOTS)-1:0]   waddr_i,
  input  entry_t                     wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(SLOTS)-1:0]   raddr_i,
  output entry_t                     rdata_o
);

  entry_t mem_q [SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/elst_upd.sv
// row and running total update for one accepted record word
// depends on elst_pkg
module elst_upd import elst_pkg::*; (
  input  entry_t            row_i,
  input  totals_t           tot_i,
  input  logic [DATA_W-1:0] dur_i,
  input  logic [DATA_W-1:0] start_i,
  output entry_t            row_o,
  output totals_t           tot_o
);

  logic [DATA_W:0] gc_sum;
  logic [DATA_W:0] gt_sum;

  always_comb begin
    row_o.count = row_i.count + DATA_W'(1);
    row_o.total = row_i.total + dur_i;
    row_o.max   = (dur_i > row_i.max) ? dur_i : row_i.max;

    // saturating grand totals
    gc_sum = {1'b0, tot_i.grand_count} + (DATA_W+1)'(1);
    gt_sum = {1'b0, tot_i.grand_time} + {1'b0, dur_i};
    tot_o.grand_count = gc_sum[DATA_W] ? '1 : gc_sum[DATA_W-1:0];
    tot_o.grand_time  = gt_sum[DATA_W] ? '1 : gt_sum[DATA_W-1:0];

    // latch the first nonzero start time
    tot_o.first_start = (tot_i.first_start == '0) ? start_i : tot_i.first_start;
  end

endmodule

// File: sv/event_latency_stats_table.sv
// event latency statistics table, top level: control, config and result registers
// depends on elst_pkg, elst_mem, elst_upd
// a taken word enters the execute state, from which its result is registered;
//   a clear word sweeps the whole table and reports when the sweep is done
// busy_o holds off new words during the row read-modify-write (read, then write)
// after reset the block clears the memory with busy_o high;
//   config writes are taken during that pass; results cannot be stalled
module event_latency_stats_table import elst_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command side
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [DATA_W-1:0]    start_time_i,
  input  logic [DATA_W-1:0]    end_time_i,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                 cfg_wdata_i,
  // result side, done_o is high for a single cycle per word
  output logic                 done_o,
  output logic                 accepted_o,
  output logic [DATA_W-1:0]    slot_count_o,
  output logic [DATA_W-1:0]    slot_total_o,
  output logic [DATA_W-1:0]    slot_max_o,
  output logic [DATA_W-1:0]    sum_count_o,
  output logic [DATA_W-1:0]    sum_time_o,
  output logic [DATA_W-1:0]    first_time_o,
  output logic [MODE_W-1:0]    mode_now_o
);

  localparam int unsigned AW = $clog2(SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_e;

  state_e            state_q;
  logic              accept;

  // config registers
  logic              record_enable_q;
  logic              steady_mode_q;

  // architectural state outside the memory
  logic [MODE_W-1:0] mode_q;
  totals_t           tot_q;

  // word held for the execute cycle
  logic [KIND_W-1:0] kind_q;
  logic [AW-1:0]     addr_q;
  logic              in_range_q;
  logic              rec_ok_q;
  logic [DATA_W-1:0] t0_q;
  logic [DATA_W-1:0] dur_q;

  // clear sweep
  logic [AW-1:0]     sweep_q;
  logic              clr_report_q;

  // result registers
  logic              done_q;
  logic              accepted_q;
  logic [DATA_W-1:0] slot_count_q;
  logic [DATA_W-1:0] slot_total_q;
  logic [DATA_W-1:0] slot_max_q;

  // word decode at accept time
  logic              in_range;
  logic [DATA_W:0]   diff;
  logic              rec_ok;

  // memory and update datapath
  entry_t            rd_row;
  entry_t            new_row;
  totals_t           new_tot;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic              rec_hit;
  logic              sweep_last;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  assign in_range = (32'(slot_i) < 32'(SLOTS));
  // borrow out of the subtraction flags end below start
  assign diff     = {1'b0, end_time_i} - {1'b0, start_time_i};
  assign rec_ok   = record_enable_q && (mode_q == MODE_RECORD) && (end_time_i != '0)
                    && !diff[DATA_W] && in_range;

  assign rec_hit    = (state_q == ST_EXEC) && (kind_q == KIND_RECORD) && rec_ok_q;
  assign sweep_last = (sweep_q == AW'(SLOTS - 1));

  // sweep writes zero rows, a record word writes back its updated row
  assign mem_we    = rec_hit || (state_q == ST_CLEAR);
  assign mem_waddr = (state_q == ST_CLEAR) ? sweep_q : addr_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : new_row;

  // the read issued at accept lands in the execute cycle; the previous word's
  // write always completes before the next accept, so no forwarding is needed
  elst_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (AW'(slot_i)),
    .rdata_o (rd_row)
  );

  elst_upd u_upd (
    .row_i   (rd_row),
    .tot_i   (tot_q),
    .dur_i   (dur_q),
    .start_i (t0_q),
    .row_o   (new_row),
    .tot_o   (new_tot)
  );

  // control state, config and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      sweep_q         <= '0;
      clr_report_q    <= 1'b0;
      done_q          <= 1'b0;
      accepted_q      <= 1'b0;
      record_enable_q <= 1'b0;
      steady_mode_q   <= 1'b0;
      mode_q          <= MODE_RECORD;
      tot_q           <= '0;
      kind_q          <= KIND_RECORD;
      rec_ok_q        <= 1'b0;
      in_range_q      <= 1'b0;
    end else begin
      done_q     <= 1'b0;
      accepted_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RECORD_ENABLE: record_enable_q <= cfg_wdata_i;
          REG_STEADY_MODE:   steady_mode_q   <= cfg_wdata_i;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            kind_q     <= kind_i;
            rec_ok_q   <= rec_ok;
            in_range_q <= in_range;
            if (kind_i == KIND_CLEAR) begin
              // zero the totals now, the sweep zeroes the rows
              state_q      <= ST_CLEAR;
              sweep_q      <= '0;
              clr_report_q <= 1'b1;
              tot_q        <= '0;
              mode_q       <= steady_mode_q ? MODE_RECORD : MODE_OFF;
            end else begin
              state_q <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
          unique case (kind_q)
            KIND_RECORD: begin
              if (rec_ok_q) begin
                tot_q      <= new_tot;
                accepted_q <= 1'b1;
              end
            end
            KIND_FREEZE: begin
              if (!steady_mode_q && (mode_q == MODE_RECORD)) begin
                mode_q <= MODE_FROZEN;
              end
            end
            KIND_STOP: begin
              mode_q <= MODE_OFF;
            end
            default: begin
              // read and unused kinds leave the state alone
            end
          endcase
        end
        ST_CLEAR: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_last) begin
            state_q      <= ST_IDLE;
            done_q       <= clr_report_q;
            clr_report_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // word payload and read-back data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= AW'(slot_i);
      t0_q   <= start_time_i;
      dur_q  <= diff[DATA_W-1:0];
    end
    if (state_q == ST_EXEC) begin
      if ((kind_q == KIND_READ) && in_range_q) begin
        slot_count_q <= rd_row.count;
        slot_total_q <= rd_row.total;
        slot_max_q   <= rd_row.max;
      end else begin
        slot_count_q <= '0;
        slot_total_q <= '0;
        slot_max_q   <= '0;
      end
    end else if (state_q == ST_CLEAR) begin
      slot_count_q <= '0;
      slot_total_q <= '0;
      slot_max_q   <= '0;
    end
  end

  // totals and mode stay put while a result is on the ports
  assign done_o       = done_q;
  assign accepted_o   = accepted_q;
  assign slot_count_o = slot_count_q;
  assign slot_total_o = slot_total_q;
  assign slot_max_o   = slot_max_q;
  assign sum_count_o  = tot_q.grand_count;
  assign sum_time_o   = tot_q.grand_time;
  assign first_time_o = tot_q.first_start;
  assign mode_now_o   = mode_q;

endmodule
